[hw/rtl/satp_pkg.sv]
// Shared types, constants and helpers for the summed-area-table power block.
package satp_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_SAMPLE_BITS = 12;

  localparam int CFG_DIM_W  = 11;
  localparam int CFG_POW_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [CFG_POW_W-1:0] POWER_RST  = 3'd1;

  localparam int SUM_W       = 64;
  localparam int MULT_CNT_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_POWER  = 2'd2
  } satp_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POW,
    ST_COL,
    ST_ROW
  } satp_state_e;

  // Classification of one sample, made by the front end
  typedef struct packed {
    logic                  row_first;
    logic                  col_first;
    logic                  frame_last;
    logic [MULT_CNT_W-1:0] mults;
  } satp_flags_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

[hw/rtl/summed_area_table_power_top.sv]
// Top level of the streaming summed-area table of sample powers.
// Samples arrive in raster order and each yields one 64-bit table entry, the saturating sum
// of sample^power (power clamped to 1..4) over the rectangle from the frame origin to that
// sample. The front end tracks position and classifies samples into a two-entry queue, so
// input keeps flowing while a result waits on the output. Per sample the back end pops it
// and reads the column-sum memory, steps the shared power multiplier, then does the column
// update and the row accumulation, and takes no new sample before its entry is registered.
// The column-sum memory holds one entry per column and needs no clearing after reset, since
// row 0 of each frame rewrites it. Change configuration only while the block is idle.
module summed_area_table_power_top import satp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SUM_W-1:0]       sat_value_o,
  output logic                   saturated_o,
  output logic                   last_of_frame_o
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int FLAGS_W = $bits(satp_flags_t);
  localparam int QW      = FLAGS_W + COL_W + SAMPLE_BITS;

  logic                   push_valid, push_ready, q_valid, q_ready;
  logic [SAMPLE_BITS-1:0] push_sample;
  logic [COL_W-1:0]       push_col;
  satp_flags_t            push_flags, q_flags;
  logic [QW-1:0]          q_data;

  assign cfg_ready_o = 1'b1;

  satp_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_sample_o (push_sample),
    .push_col_o    (push_col),
    .push_flags_o  (push_flags)
  );

  satp_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flags, push_col, push_sample}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_flags = satp_flags_t'(q_data[QW-1 -: FLAGS_W]);

  satp_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (q_valid),
    .pop_ready_o     (q_ready),
    .pop_sample_i    (q_data[SAMPLE_BITS-1:0]),
    .pop_col_i       (q_data[SAMPLE_BITS +: COL_W]),
    .pop_flags_i     (q_flags),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sat_value_o     (sat_value_o),
    .saturated_o     (saturated_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // An accepted request is always visible to the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> q_valid)
    else $error("accepted request missing from queue");

  // An empty queue must never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> in_ready_o)
    else $error("input stalled with empty queue");

  // Saturation flag tracks an all-ones entry exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (saturated_o == (&sat_value_o)))
    else $error("saturation flag disagrees with entry");

endmodule

[hw/rtl/satp_front.sv]
// Front end: configuration registers, raster position tracking and sample classification.
module satp_front import satp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output logic [SAMPLE_BITS-1:0] push_sample_o,
  output logic [COL_W-1:0]       push_col_o,
  output satp_flags_t            push_flags_o
);

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCMP  = (CFG_DIM_W > COL_W + 1) ? CFG_DIM_W : COL_W + 1;
  localparam int HCMP  = (CFG_DIM_W > ROW_W + 1) ? CFG_DIM_W : ROW_W + 1;

  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [CFG_POW_W-1:0] power_q;
  logic [COL_W-1:0]     col_q;
  logic [ROW_W-1:0]     row_q;

  logic [WCMP-1:0] width_eff, col_next;
  logic [HCMP-1:0] height_eff, row_next;
  logic            row_end, frame_end, take;
  logic [MULT_CNT_W-1:0] mults;

  assign take = in_valid_i && push_ready_i;

  always_comb begin
    if (width_q == '0) begin
      width_eff = WCMP'(1);
    end else if (WCMP'(width_q) > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = WCMP'(width_q);
    end
    if (height_q == '0) begin
      height_eff = HCMP'(1);
    end else if (HCMP'(height_q) > HCMP'(MAX_HEIGHT)) begin
      height_eff = HCMP'(MAX_HEIGHT);
    end else begin
      height_eff = HCMP'(height_q);
    end
  end

  always_comb begin
    unique case (power_q)
      3'd0, 3'd1: mults = 2'd0;
      3'd2:       mults = 2'd1;
      3'd3:       mults = 2'd2;
      default:    mults = 2'd3;
    endcase
  end

  assign col_next  = WCMP'(col_q) + WCMP'(1);
  assign row_next  = HCMP'(row_q) + HCMP'(1);
  assign row_end   = col_next >= width_eff;
  assign frame_end = row_end && (row_next >= height_eff);

  assign in_ready_o    = push_ready_i;
  assign push_valid_o  = in_valid_i;
  assign push_sample_o = sample_i;
  assign push_col_o    = col_q;
  assign push_flags_o  = '{row_first:  (row_q == '0),
                           col_first:  (col_q == '0),
                           frame_last: frame_end,
                           mults:      mults};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      power_q  <= POWER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_POWER:  power_q  <= cfg_data_i[CFG_POW_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the raster position, wrap at row and frame ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

endmodule

[hw/rtl/satp_queue.sv]
// Short request queue between the front end and the back end.
module satp_queue import satp_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/satp_back.sv]
// Back end: power sequencer, column-sum memory, row accumulator and output register.
module satp_back import satp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  logic [SAMPLE_BITS-1:0] pop_sample_i,
  input  logic [COL_W-1:0]       pop_col_i,
  input  satp_flags_t            pop_flags_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SUM_W-1:0]       sat_value_o,
  output logic                   saturated_o,
  output logic                   last_of_frame_o
);

  localparam int TW = 4 * SAMPLE_BITS;

  satp_state_e state_q, state_d;

  logic [SUM_W-1:0]       col_mem [MAX_WIDTH];
  logic [SUM_W-1:0]       rd_q, cs_q, acc_q, cs_d, acc_d, value_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [COL_W-1:0]       col_q;
  satp_flags_t            flags_q;
  logic [MULT_CNT_W-1:0]  cnt_q;
  logic [TW-1:0]          term_q;
  logic [TW+SAMPLE_BITS-1:0] prod;
  logic                   out_valid_q, sat_q, last_q;
  logic                   out_free, take, mult_step, col_wr, row_ld;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = pop_valid_i && pop_ready_o;
  assign prod     = term_q * smp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop_valid_i) state_d = ST_POW;
      ST_POW:  if (cnt_q == '0) state_d = ST_COL;
      ST_COL:  state_d = ST_ROW;
      ST_ROW:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    mult_step   = 1'b0;
    col_wr      = 1'b0;
    row_ld      = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_ready_o = 1'b1;
      ST_POW:  mult_step   = cnt_q != '0;
      ST_COL:  col_wr      = 1'b1;
      ST_ROW:  row_ld      = out_free;
      default: ;
    endcase
  end

  // Row 0 starts the column sum afresh; column 0 restarts the row accumulator
  assign cs_d  = flags_q.row_first ? SUM_W'(term_q) : sat_add(rd_q, SUM_W'(term_q));
  assign acc_d = flags_q.col_first ? cs_q : sat_add(acc_q, cs_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q <= col_mem[pop_col_i];
    end
    if (col_wr) begin
      col_mem[col_q] <= cs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      smp_q   <= pop_sample_i;
      col_q   <= pop_col_i;
      flags_q <= pop_flags_i;
      term_q  <= TW'(pop_sample_i);
    end else if (mult_step) begin
      term_q  <= prod[TW-1:0];
    end
    if (col_wr) begin
      cs_q <= cs_d;
    end
    if (row_ld) begin
      value_q <= acc_d;
      sat_q   <= &acc_d;
      last_q  <= flags_q.frame_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        cnt_q <= pop_flags_i.mults;
      end else if (mult_step) begin
        cnt_q <= cnt_q - MULT_CNT_W'(1);
      end
      if (row_ld) begin
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sat_value_o     = value_q;
  assign saturated_o     = sat_q;
  assign last_of_frame_o = last_q;

endmodule

[tb/sv/satp_result_checker.sv]
// Result checker for the summed-area-table power block: predicts each table entry and compares.
`timescale 1ns / 100ps
module satp_result_checker import satp_pkg::*; #(
  parameter int MAX_W    = DEF_MAX_WIDTH,
  parameter int MAX_H    = DEF_MAX_HEIGHT,
  parameter int SAMPLE_W = DEF_SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [SUM_W-1:0]      sat_value_i,
  input  logic                  saturated_i,
  input  logic                  last_of_frame_i,
  output int                    mismatches_o,
  output int                    backlog_o
);

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             clamped;
    logic             frame_end;
  } sat_entry_t;

  sat_entry_t entry_q[$];
  sat_entry_t want;

  logic [SUM_W-1:0]     col_sum [MAX_W];
  logic [SUM_W-1:0]     row_sum;
  int unsigned          col_at, row_at;
  logic [CFG_DIM_W-1:0] width_reg, height_reg;
  logic [CFG_POW_W-1:0] power_reg;
  int                   mismatches;
  int                   backlog;

  assign mismatches_o = mismatches;
  assign backlog_o    = backlog;

  function automatic int unsigned in_use(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  // Advance the running column and row sums by one sample and return its table entry
  function automatic sat_entry_t predict_entry(input logic [SAMPLE_W-1:0] s);
    sat_entry_t       e;
    int unsigned      w, h, pw, k, col;
    logic [SUM_W-1:0] term, cs;
    logic             row_done;
    w    = in_use(width_reg, MAX_W);
    h    = in_use(height_reg, MAX_H);
    pw   = in_use(power_reg, 4);
    col  = (col_at >= MAX_W) ? MAX_W - 1 : col_at;
    term = SUM_W'(s);
    for (k = 1; k < pw; k++) term = term * SUM_W'(s);
    cs           = (row_at == 0) ? term : add_clamped(col_sum[col], term);
    col_sum[col] = cs;
    row_sum      = (col == 0) ? cs : add_clamped(row_sum, cs);
    row_done     = (col_at + 1 >= w);
    e.value      = row_sum;
    e.clamped    = &row_sum;
    e.frame_end  = row_done && (row_at + 1 >= h);
    if (row_done) begin
      col_at = 0;
      row_at = e.frame_end ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.delete();
      row_sum    = '0;
      col_at     = 0;
      row_at     = 0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      power_reg  = POWER_RST;
      mismatches = 0;
      backlog   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_reg = cfg_data_i;
          CFG_HEIGHT: height_reg = cfg_data_i;
          CFG_POWER:  power_reg = cfg_data_i[CFG_POW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) entry_q.push_back(predict_entry(sample_i));
      if (out_valid_i && out_ready_i) begin
        if (entry_q.size() == 0) begin
          if (mismatches < 10)
            $display("entry with no request pending: %h/%0b/%0b",
                     sat_value_i, saturated_i, last_of_frame_i);
          mismatches++;
        end else begin
          want = entry_q.pop_front();
          if (want.value !== sat_value_i || want.clamped !== saturated_i ||
              want.frame_end !== last_of_frame_i) begin
            if (mismatches < 10)
              $display("entry mismatch (value/saturated/last): expected %h/%0b/%0b, got %h/%0b/%0b",
                       want.value, want.clamped, want.frame_end,
                       sat_value_i, saturated_i, last_of_frame_i);
            mismatches++;
          end
        end
      end
      backlog <= entry_q.size();
    end
  end

endmodule

[tb/sv/tb_summed_area_table_power_top.sv]
// Stimulus and verdict for the summed-area-table power block.
`timescale 1ns / 100ps
module tb_summed_area_table_power_top;
  import satp_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
  localparam int RANDOM_SAMPLES = 1300;
  localparam int TAIL_SAMPLES   = 64;
  localparam int HOLD_PUSHES    = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 200_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [SAMPLE_W-1:0]  FULL_SCALE = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i, in_ready_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o, out_ready_i;
  logic [SUM_W-1:0]      sat_value_o;
  logic                  saturated_o, last_of_frame_o;
  int                    mismatches, backlog;

  int idle_pct     = 0;
  bit quiet        = 1'b0;
  bit hold_req     = 1'b0;
  // position of the next request as the block will see it
  int unsigned          next_col  = 0;
  int unsigned          next_row  = 0;
  int unsigned          cols_seen = 0;
  logic [CFG_DIM_W-1:0] width_set  = WIDTH_RST;
  logic [CFG_DIM_W-1:0] height_set = HEIGHT_RST;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  summed_area_table_power_top dut (.*);

  satp_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sat_value_i    (sat_value_o),
    .saturated_i    (saturated_o),
    .last_of_frame_i(last_of_frame_o),
    .mismatches_o   (mismatches),
    .backlog_o      (backlog)
  );

  function automatic int unsigned dim_in_use(input logic [CFG_DIM_W-1:0] v,
                                             input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Leaves cfg_valid_i high; the caller drops it after the last write
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WIDTH) width_set = data;
    else if (idx == CFG_HEIGHT) height_set = data;
  endtask

  // Leaves in_valid_i high after the request is taken, so back-to-back requests never glitch
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    logic row_done;
    if (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    if (next_col + 1 > cols_seen) cols_seen = next_col + 1;
    row_done = (next_col + 1 >= dim_in_use(width_set, MAX_W));
    if (!row_done) begin
      next_col++;
    end else begin
      next_col = 0;
      next_row = (next_row + 1 >= dim_in_use(height_set, MAX_H)) ? 0 : next_row + 1;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
  endtask

  // Close the current frame with a one-sample frame so the next phase starts at the origin
  task automatic restart_frame();
    set_reg(CFG_WIDTH, CFG_DATA_W'(1));
    set_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    cfg_valid_i <= 1'b0;
    push_sample(pick_sample());
    drain();
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_summed_area_table_power_top: done, errors");
    $finish;
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && hold_req) begin
        // hold off long enough for the queue to fill and stall the input
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int                    rand_sent;
    int unsigned           pick, n;
    logic [CFG_DATA_W-1:0] wdata;
    rand_sent    = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x2 frame at power 1 with extreme samples; the spare index must be ignored
    set_reg(CFG_WIDTH, CFG_DATA_W'(3));
    set_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    set_reg(CFG_POWER, CFG_DATA_W'(1));
    set_reg(CFG_SPARE, '1);
    cfg_valid_i <= 1'b0;
    push_sample(FULL_SCALE);
    push_sample('0);
    push_sample(SAMPLE_W'(1));
    push_sample(SAMPLE_W'(2048));
    push_sample(FULL_SCALE);
    push_sample(FULL_SCALE);
    drain();

    // zero width and zero power fall back to 1
    set_reg(CFG_WIDTH, '0);
    set_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    set_reg(CFG_POWER, '0);
    cfg_valid_i <= 1'b0;
    push_sample(FULL_SCALE);
    push_sample(FULL_SCALE);
    drain();

    set_reg(CFG_WIDTH, CFG_DATA_W'(2));
    set_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    set_reg(CFG_POWER, CFG_DATA_W'(4));
    cfg_valid_i <= 1'b0;
    push_sample(FULL_SCALE);
    push_sample(FULL_SCALE);
    drain();

    // oversized dimensions act as the maximum, then shrink width, raise power and shrink height mid-frame
    set_reg(CFG_WIDTH, '1);
    set_reg(CFG_HEIGHT, '1);
    set_reg(CFG_POWER, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    repeat (4) push_sample(pick_sample());
    drain();
    set_reg(CFG_WIDTH, CFG_DATA_W'(2));
    cfg_valid_i <= 1'b0;
    push_sample(pick_sample());
    drain();
    set_reg(CFG_POWER, CFG_DATA_W'(3));
    cfg_valid_i <= 1'b0;
    repeat (2) push_sample(pick_sample());
    drain();
    set_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    cfg_valid_i <= 1'b0;
    repeat (2) push_sample(pick_sample());

    // hold the result side off while requests keep coming, so the queue fills
    drain();
    hold_req = 1'b1;
    repeat (HOLD_PUSHES) push_sample(pick_sample());

    while (rand_sent < RANDOM_SAMPLES) begin
      drain();
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if ($urandom_range(7) == 0) restart_frame();
      if ($urandom_range(1) == 1) begin
        pick = $urandom_range(99);
        if (pick < 5) wdata = '0;
        else if (pick == 5) wdata = CFG_DATA_W'(MAX_W);
        else if (pick < 8) wdata = '1;
        else if (pick < 12) wdata = CFG_DATA_W'($urandom_range(MAX_W + 1, 2047));
        else if (pick < 30) wdata = CFG_DATA_W'($urandom_range(9, 64));
        else wdata = CFG_DATA_W'($urandom_range(1, 8));
        // a later row must not reach a column that no request has written yet
        if (next_row != 0 && dim_in_use(wdata, MAX_W) > cols_seen)
          wdata = CFG_DATA_W'($urandom_range(1, cols_seen));
        set_reg(CFG_WIDTH, wdata);
      end
      if ($urandom_range(1) == 1) begin
        pick = $urandom_range(99);
        if (pick < 5) wdata = '0;
        else if (pick < 7) wdata = '1;
        else if (pick < 20) wdata = CFG_DATA_W'($urandom_range(7, 40));
        else wdata = CFG_DATA_W'($urandom_range(1, 6));
        set_reg(CFG_HEIGHT, wdata);
      end
      if ($urandom_range(1) == 1) set_reg(CFG_POWER, CFG_DATA_W'($urandom));
      if ($urandom_range(15) == 0) set_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_valid_i <= 1'b0;
      n = $urandom_range(1, 48);
      repeat (n) begin
        push_sample(pick_sample());
        rand_sent++;
      end
    end

    // full-scale run at the widest setting with power above range, no idling
    drain();
    quiet = 1'b1;
    restart_frame();
    set_reg(CFG_WIDTH, CFG_DATA_W'(MAX_W));
    set_reg(CFG_HEIGHT, CFG_DATA_W'(MAX_H));
    set_reg(CFG_POWER, CFG_DATA_W'(7));
    cfg_valid_i <= 1'b0;
    repeat (TAIL_SAMPLES) push_sample(FULL_SCALE);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && backlog == 0) begin
      $display("tb_summed_area_table_power_top: done, clean");
    end else begin
      $display("tb_summed_area_table_power_top: done, errors");
    end
    $finish;
  end

endmodule
